### rtl/trace_record_ring_buffer_macros.svh
// assertion macros for the trace record ring buffer
`ifndef TRACE_RECORD_RING_BUFFER_MACROS_SVH
`define TRACE_RECORD_RING_BUFFER_MACROS_SVH

// invariant checked at every clock edge outside reset
`define TRC_CHECK(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// implication checked at every clock edge outside reset
`define TRC_CHECK_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

### rtl/trc_pkg.sv
// shared types, constants and ring index helper for the trace record ring buffer
`default_nettype none

package trc_pkg;

	localparam int CAPACITY = 64;
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int ID_W = 22;
	localparam int ST_W = 12;
	localparam int SEQ_W = 32;

	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
	localparam logic [IDX_W:0] CAP_IDX = (IDX_W + 1)'(CAPACITY);
	localparam logic [IDX_W-1:0] IDX_ONE = IDX_W'(1);
	localparam logic [SEQ_W-1:0] SEQ_MAX = '1;

	localparam logic [1:0] REQ_RECORD = 2'd0;
	localparam logic [1:0] REQ_GET = 2'd1;
	localparam logic [1:0] REQ_CLEAR = 2'd2;

	typedef struct packed {
		logic [ID_W-1:0] id;
		logic [ST_W-1:0] st;
		logic [SEQ_W-1:0] seq;
	} entry_t;

	typedef struct packed {
		logic [SEQ_W:0] lo;
		logic [SEQ_W:0] hi;
		logic [ID_W-1:0] id;
		logic all;
	} win_t;

	typedef struct packed {
		logic id_eq;
		logic hit;
	} match_t;

	function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] a,
			input logic [IDX_W-1:0] b);
		logic [IDX_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= CAP_IDX) begin
			s = s - CAP_IDX;
		end
		return s[IDX_W-1:0];
	endfunction

endpackage

`default_nettype wire

### rtl/trc_mem.sv
// entry storage: one write port, one registered read port
`default_nettype none

module trc_mem
	import trc_pkg::*;
(
	input wire logic clk,
	input wire logic wr_en,
	input wire logic [IDX_W-1:0] wr_addr,
	input wire entry_t wr_data,
	input wire logic rd_en,
	input wire logic [IDX_W-1:0] rd_addr,
	output entry_t rd_data
);

	entry_t mem [CAPACITY];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

### rtl/trc_match.sv
// shared compare unit: id equality and sequence window test on one entry
`default_nettype none

module trc_match
	import trc_pkg::*;
(
	input wire entry_t ent,
	input wire win_t win,
	output match_t res
);

	logic [SEQ_W:0] seq_x;
	logic in_win;

	always_comb begin
		seq_x = {1'b0, ent.seq};
		in_win = (seq_x >= win.lo) && (seq_x <= win.hi);
		res.id_eq = (ent.id == win.id);
		res.hit = (win.all || res.id_eq) && in_win;
	end

endmodule

`default_nettype wire

### rtl/trace_record_ring_buffer.sv
// trace record ring buffer top: request sequencer, ring pointers and result register
//
//   channel | handshake            | payload
//   --------+----------------------+---------------------------------------------
//   request | req_valid/req_ready  | req_type proc_id all_ids task_state seq_after
//   result  | rsp_valid/rsp_ready  | rec_valid rec_id rec_state rec_seq last
//
// record finishes in IDLE, or passes through RFIX when the store is full (the next oldest seq is read back)
// get walks the fill_count live entries at one memory read a cycle while the result port does not stall,
// then pushes the last marker from GEND; an empty store or an expired window skips the reads
// clear of one id walks and compacts at one read a cycle, writing each kept entry back
// clear of all ids completes in IDLE; a stalled result port pauses the get walk
// reset clears state, pointers, counters and flags only; entries are defined once written
`default_nettype none

module trace_record_ring_buffer
	import trc_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	output logic req_ready,
	input wire logic [1:0] req_type,
	input wire logic [ID_W-1:0] proc_id,
	input wire logic all_ids,
	input wire logic [ST_W-1:0] task_state,
	input wire logic [SEQ_W-1:0] seq_after,
	output logic rsp_valid,
	input wire logic rsp_ready,
	output logic rec_valid,
	output logic [ID_W-1:0] rec_id,
	output logic [ST_W-1:0] rec_state,
	output logic [SEQ_W-1:0] rec_seq,
	output logic last
);

	`include "trace_record_ring_buffer_macros.svh"

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RFIX = 3'd1;
	localparam logic [2:0] S_GSCAN = 3'd2;
	localparam logic [2:0] S_GEND = 3'd3;
	localparam logic [2:0] S_CSCAN = 3'd4;

	logic [2:0] state_q;
	logic [IDX_W-1:0] oldest_q, next_q, dst_q;
	logic [CNT_W-1:0] fill_q, k_q, kept_q;
	logic [SEQ_W-1:0] oldest_seq_q, newest_seq_q;
	win_t win_q;
	logic expired_q, rd_pend_q;
	entry_t hold_q;
	logic hold_valid_q;

	logic req_ok, full, more, out_free, hit, stall, out_load, out_last;
	logic [SEQ_W-1:0] seq_next;
	logic after0, expired_new;
	logic [SEQ_W:0] lo_new, hi_new;
	logic [IDX_W-1:0] rd_off, rd_addr, wr_addr, exp_next;
	logic rd_en, wr_en;
	entry_t wr_data, rd_data;
	match_t mres;

	trc_mem u_mem (
		.clk (clk),
		.wr_en (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	trc_match u_match (
		.ent (rd_data),
		.win (win_q),
		.res (mres)
	);

	assign req_ready = (state_q == S_IDLE);
	assign req_ok = req_valid && req_ready;
	assign full = (fill_q == CAP_CNT);
	assign seq_next = (newest_seq_q == SEQ_MAX) ? newest_seq_q : newest_seq_q + 1'b1;
	assign more = !expired_q && (k_q < fill_q);
	assign out_free = !rsp_valid || rsp_ready;
	assign hit = rd_pend_q && mres.hit;
	assign stall = hit && hold_valid_q && !out_free;

	// get window, sums kept one bit wider so they never wrap
	assign after0 = (seq_after == '0);
	assign lo_new = after0 ? {1'b0, oldest_seq_q} : {1'b0, seq_after} + 1'b1;
	assign hi_new = after0 ? {1'b0, newest_seq_q} :
		{1'b0, seq_after} + (SEQ_W + 1)'(CAPACITY);
	assign expired_new = !after0 && (hi_new < {1'b0, oldest_seq_q});

	// one index adder serves the record lookahead and the walks
	assign rd_off = (state_q == S_IDLE) ? IDX_ONE : k_q[IDX_W-1:0];
	assign rd_addr = ring_add(oldest_q, rd_off);

	always_comb begin
		rd_en = 1'b0;
		wr_en = 1'b0;
		wr_addr = next_q;
		wr_data = '{id: proc_id, st: task_state, seq: seq_next};
		out_load = 1'b0;
		out_last = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (req_ok && req_type == REQ_RECORD) begin
					wr_en = 1'b1;
					rd_en = full;
				end
			end
			S_GSCAN: begin
				if (!stall) begin
					rd_en = more;
					out_load = hit && hold_valid_q;
				end
			end
			S_GEND: begin
				out_load = out_free;
				out_last = 1'b1;
			end
			S_CSCAN: begin
				rd_en = more;
				if (rd_pend_q && !mres.id_eq) begin
					wr_en = 1'b1;
					wr_addr = dst_q;
					wr_data = rd_data;
				end
			end
			default: begin
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			oldest_q <= '0;
			next_q <= '0;
			fill_q <= '0;
			oldest_seq_q <= '0;
			newest_seq_q <= '0;
			rd_pend_q <= 1'b0;
			hold_valid_q <= 1'b0;
			rsp_valid <= 1'b0;
		end else begin
			if (out_load) begin
				rsp_valid <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_ok) begin
						unique case (req_type)
							REQ_RECORD: begin
								newest_seq_q <= seq_next;
								next_q <= ring_add(next_q, IDX_ONE);
								if (full) begin
									oldest_q <= ring_add(oldest_q, IDX_ONE);
									state_q <= S_RFIX;
								end else begin
									fill_q <= fill_q + 1'b1;
									if (fill_q == '0) begin
										oldest_seq_q <= seq_next;
									end
								end
							end
							REQ_GET: begin
								rd_pend_q <= 1'b0;
								hold_valid_q <= 1'b0;
								state_q <= S_GSCAN;
							end
							REQ_CLEAR: begin
								if (fill_q != '0) begin
									if (all_ids) begin
										fill_q <= '0;
										next_q <= oldest_q;
									end else begin
										rd_pend_q <= 1'b0;
										state_q <= S_CSCAN;
									end
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_RFIX: begin
					oldest_seq_q <= rd_data.seq;
					state_q <= S_IDLE;
				end
				S_GSCAN: begin
					if (!stall) begin
						if (hit) begin
							hold_valid_q <= 1'b1;
						end
						rd_pend_q <= more;
						if (!rd_pend_q && !more) begin
							state_q <= S_GEND;
						end
					end
				end
				S_GEND: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_CSCAN: begin
					rd_pend_q <= more;
					if (!rd_pend_q && !more) begin
						fill_q <= kept_q;
						next_q <= dst_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// walk payload
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				k_q <= '0;
				kept_q <= '0;
				dst_q <= oldest_q;
				win_q <= '{lo: lo_new, hi: hi_new, id: proc_id, all: all_ids};
				expired_q <= (req_type == REQ_GET) && expired_new;
			end
			S_GSCAN: begin
				if (!stall) begin
					if (hit) begin
						hold_q <= rd_data;
					end
					if (more) begin
						k_q <= k_q + 1'b1;
					end
				end
			end
			S_CSCAN: begin
				if (rd_pend_q && !mres.id_eq) begin
					dst_q <= ring_add(dst_q, IDX_ONE);
					kept_q <= kept_q + 1'b1;
				end
				if (more) begin
					k_q <= k_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// result register
	always_ff @(posedge clk) begin
		if (out_load) begin
			rec_valid <= hold_valid_q;
			rec_id <= hold_valid_q ? hold_q.id : '0;
			rec_state <= hold_valid_q ? hold_q.st : '0;
			rec_seq <= hold_valid_q ? hold_q.seq : '0;
			last <= out_last;
		end
	end

	assign exp_next = full ? oldest_q : ring_add(oldest_q, fill_q[IDX_W-1:0]);

	`TRC_CHECK(a_fill_bound, fill_q <= CAP_CNT, "fill count above capacity")
	`TRC_CHECK_IMP(a_ring_link, state_q == S_IDLE, next_q == exp_next, "write pointer off ring")
	`TRC_CHECK_IMP(a_scan_push, state_q == S_GSCAN && !hold_valid_q, !out_load,
		"result pushed with nothing held")
	`TRC_CHECK_IMP(a_kept_bound, state_q == S_CSCAN, kept_q <= k_q, "kept count ahead of walk")

endmodule

`default_nettype wire
